FILE: rtl/core/iis_pkg.sv
package iis_pkg;

    localparam int TIME_W      = 62;  // timestamps and sample index
    localparam int STATE_W     = 63;  // mixed number, position, interval count
    localparam int STEP_W      = 61;
    localparam int DIV_W       = 64;  // dividend magnitude
    localparam int CNT_W       = 6;   // divider step counter, DIV_W steps
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 62;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd2;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [STATE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
        logic [STATE_W-1:0] remainder;
    } t_div_rsp;

endpackage

FILE: rtl/core/iis_div.sv
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
module iis_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iis_pkg::t_div_req i_req,
    output iis_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [iis_pkg::CNT_W-1:0]   r_cnt;
    logic [iis_pkg::DIV_W-1:0]   r_quo;
    logic [iis_pkg::STATE_W-1:0] r_rem;
    logic [iis_pkg::STATE_W-1:0] r_dvs;
    logic [iis_pkg::DIV_W:0]     w_trial;

    // partial remainder with next dividend bit, minus divisor
    assign w_trial = {1'b0, r_rem, r_quo[iis_pkg::DIV_W-1]} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == iis_pkg::CNT_W'(iis_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[iis_pkg::DIV_W-2:0], ~w_trial[iis_pkg::DIV_W]};
            if (!w_trial[iis_pkg::DIV_W]) begin
                r_rem <= w_trial[iis_pkg::STATE_W-1:0];
            end else begin
                r_rem <= {r_rem[iis_pkg::STATE_W-2:0], r_quo[iis_pkg::DIV_W-1]};
            end
        end
    end

    assign o_rsp = {r_done, r_quo, r_rem};

endmodule

FILE: rtl/core/integer_interval_sampler.sv
// Path of a request inside a sweep: prep, magnitude, sum division, fix-up, output; the first
//   sample of a sweep does the sample count division first, equal endpoints go straight to output.
// One request at a time, with none, one or two 64-step divider passes each; the next
//   request is taken only once the sample is in the output register.
// Reset (synchronous, active low): no sweep running, output empty, registers
//   first_time = 0, final_time = 0, step_limit = 1.
module integer_interval_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [iis_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [0] begin_anew, [7:1] zero
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [iis_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // [61:0] point_time,
                                                           // [123:62] point_index, [127:124] 0
    output logic                              o_m_tlast,   // final_point
    input  logic                              i_cfg_we,
    input  logic [iis_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [iis_pkg::CFG_W-1:0]         i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,  // ready for a request
        ST_CDIV = 7'b0000010,  // sample count division
        ST_PREP = 7'b0000100,  // rounding, last flag, numerator + total
        ST_ABS  = 7'b0001000,  // magnitude of the sum, sample time
        ST_SDIV = 7'b0010000,  // sum / intervals
        ST_FIX  = 7'b0100000,  // signed quotient/remainder back into state
        ST_OUT  = 7'b1000000   // wait for the output register
    } t_state;

    localparam int TW = iis_pkg::TIME_W;
    localparam int SW = iis_pkg::STATE_W;
    localparam int DW = iis_pkg::DIV_W;

    t_state r_state, n_state;

    // configuration
    logic [TW-1:0]              r_first;
    logic [TW-1:0]              r_final;
    logic [iis_pkg::STEP_W-1:0] r_step;

    // sweep state: offset = whole + num / ivals
    logic [SW-1:0] r_whole;
    logic [SW-1:0] r_num;
    logic [SW-1:0] r_pos;
    logic [SW-1:0] r_ivals;
    logic          r_run;

    // working registers
    logic [DW-1:0] r_dvd;
    logic [SW-1:0] r_dvs;
    logic          r_go;
    logic          r_neg;
    logic          r_rnd;
    logic [TW-1:0] r_ptime;
    logic [TW-1:0] r_pidx;
    logic          r_plast;

    // output register
    logic          r_m_valid;
    logic [TW-1:0] r_m_time;
    logic [TW-1:0] r_m_idx;
    logic          r_m_last;

    iis_pkg::t_div_req w_req;
    iis_pkg::t_div_rsp w_rsp;

    logic [SW-1:0] w_total;
    logic          w_total_zero;
    logic          w_accept;
    logic          w_new;
    logic [SW-1:0] w_ivals;
    logic [SW:0]   w_ivals_p1;
    logic [SW-1:0] w_half;
    logic          w_round;
    logic          w_last;
    logic [DW-1:0] w_sum;
    logic [SW-1:0] w_mag_m1;
    logic [SW-1:0] w_step;
    logic          w_load;

    // total = final - first, both sign-extended; fits 63 bits
    assign w_total      = {r_final[TW-1], r_final} - {r_first[TW-1], r_first};
    assign w_total_zero = (w_total == '0);

    assign w_accept = i_s_tvalid & o_s_tready;
    assign w_new    = i_s_tdata[0] | ~r_run;

    // |total| - 1: for negative total that is simply ~total
    assign w_mag_m1 = w_total[SW-1] ? ~w_total : (w_total - 1'b1);
    assign w_step   = (r_step == '0) ? SW'(1) : {2'b00, r_step};

    // interval count clamped to at least one
    assign w_ivals    = (r_ivals == '0) ? SW'(1) : r_ivals;
    assign w_ivals_p1 = {1'b0, w_ivals} + 1'b1;
    assign w_half     = w_ivals_p1[SW:1];
    // round up when the numerator reaches half an interval (never if negative)
    assign w_round    = ~r_num[SW-1] & (r_num >= w_half);
    assign w_last     = (r_pos >= w_ivals);
    assign w_sum      = {r_num[SW-1], r_num} + {w_total[SW-1], w_total};

    assign w_load = (r_state == ST_OUT) & (~r_m_valid | i_m_tready);

    assign w_req = {r_go, r_dvd, r_dvs};

    iis_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_new && w_total_zero) begin
                        n_state = ST_OUT;
                    end else if (w_new) begin
                        n_state = ST_CDIV;
                    end else begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_CDIV: if (w_rsp.done) n_state = ST_PREP;
            ST_PREP: n_state = ST_ABS;
            ST_ABS:  n_state = ST_SDIV;
            ST_SDIV: if (w_rsp.done) n_state = ST_FIX;
            ST_FIX:  n_state = ST_OUT;
            ST_OUT:  if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control, configuration and sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_first   <= '0;
            r_final   <= '0;
            r_step    <= iis_pkg::STEP_W'(1);
            r_whole   <= '0;
            r_num     <= '0;
            r_pos     <= '0;
            r_ivals   <= '0;
            r_run     <= 1'b0;
            r_go      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    iis_pkg::CFG_FIRST: r_first <= i_cfg_data;
                    iis_pkg::CFG_FINAL: r_final <= i_cfg_data;
                    iis_pkg::CFG_STEP:  r_step  <= i_cfg_data[iis_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_new) begin
                        r_whole <= '0;
                        r_num   <= '0;
                        r_pos   <= '0;
                        if (w_total_zero) begin
                            r_run   <= 1'b0;
                            r_ivals <= '0;
                        end else begin
                            r_go <= 1'b1;
                        end
                    end
                end
                ST_CDIV: begin
                    if (w_rsp.done) begin
                        // intervals = samples - 1 = quotient + 1
                        r_ivals <= w_rsp.quotient[SW-1:0] + 1'b1;
                        r_run   <= 1'b1;
                    end
                end
                ST_ABS: r_go <= 1'b1;
                ST_FIX: begin
                    // truncating signed division: quotient and remainder take
                    // the sign of the sum, divisor is positive
                    r_whole <= r_neg ? (r_whole - w_rsp.quotient[SW-1:0])
                                     : (r_whole + w_rsp.quotient[SW-1:0]);
                    r_num   <= r_neg ? (~w_rsp.remainder + 1'b1) : w_rsp.remainder;
                    r_pos   <= r_pos + 1'b1;
                    if (r_plast) r_run <= 1'b0;
                end
                default: ;
            endcase

            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // equal endpoints: single sample at first_time
                    r_ptime <= r_first;
                    r_pidx  <= '0;
                    r_plast <= 1'b1;
                    r_dvd   <= {1'b0, w_mag_m1};
                    r_dvs   <= w_step;
                end
            end
            ST_PREP: begin
                r_pidx  <= r_pos[TW-1:0];
                r_plast <= w_last;
                r_rnd   <= w_round;
                r_neg   <= w_sum[DW-1];
                r_dvd   <= w_sum;
            end
            ST_ABS: begin
                r_dvd   <= r_neg ? (~r_dvd + 1'b1) : r_dvd;
                r_dvs   <= w_ivals;
                r_ptime <= r_first + r_whole[TW-1:0] + {{(TW-1){1'b0}}, r_rnd};
            end
            default: ;
        endcase

        if (w_load) begin
            r_m_time <= r_ptime;
            r_m_idx  <= r_pidx;
            r_m_last <= r_plast;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(iis_pkg::OUT_TDATA_W - 2 * TW){1'b0}}, r_m_idx, r_m_time};
    assign o_m_tlast  = r_m_last;

endmodule

FILE: rtl/core/iis_chk.sv
module iis_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [iis_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                            o_m_tlast
);

    // after reset: ready for a request, nothing on the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready && !o_m_tvalid)
        else $error("state after reset wrong");

    // a request is never followed by another in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after a request");

    // a new sample appears only at the end of work on a request
    a_rose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("sample without a request in progress");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled sample changed");

endmodule

bind integer_interval_sampler iis_chk u_iis_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast)
);
